[hw/rtl/gpt_pkg.sv]
// Package for the grid path tracer: sizes, field layouts, codes and the
// command and status bundles between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package gpt_pkg;

    // Grid storage and field widths.
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 32;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 5;
    localparam int RIU_W    = 5;
    localparam int CIU_W    = 6;
    localparam int ID_W     = 9;
    localparam int STAT_W   = 2;
    localparam int ACT_W    = 2;

    // Configuration port.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;
    localparam logic [RIU_W-1:0] RIU_RESET = RIU_W'(11);
    localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(19);

    // Action codes of an input word.
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STEP  = 2'd2;

    // Status codes of a result word.
    localparam logic [STAT_W-1:0] ST_CELL     = 2'd0;
    localparam logic [STAT_W-1:0] ST_WRITTEN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_TRACE = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             cell_on;
    } t_in_word;

    typedef struct packed {
        logic [ID_W-1:0]   cell_id;
        logic              last;
        logic [STAT_W-1:0] status;
    } t_out_word;

    // Which neighbor row the map read port fetches.
    typedef enum logic [1:0] {
        RD_DN  = 2'd0,
        RD_UP  = 2'd1,
        RD_MID = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic              load;
        logic              path_wr;
        logic              start_enter;
        logic              step_enter;
        logic              rd_en;
        t_rd_sel           rd_sel;
        logic              cap_dn;
        logic              cap_up;
        logic              res_set;
        logic [STAT_W-1:0] res_status;
        logic              res_last;
        logic              active_wr;
        logic              active_val;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             in_range;
        logic             active;
        logic             found;
        logic             out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[hw/rtl/grid_path_tracer_top.sv]
// Top level of the grid path tracer: configuration registers, controller and datapath.
// Depends on gpt_pkg, gpt_ctrl, gpt_datapath.
//
// The block keeps a bitmap of path cells and traces the path greedily. Input words
// arrive on i_in_valid/o_in_stall/i_in_word: a write word sets or clears one map cell,
// a start word begins a trace at a cell, and a step word moves to the first unvisited
// path neighbor in the order down, up, left, right. Each input word gives exactly one
// result word on o_out_valid/i_out_stall/o_out_word with the cell id, a last flag and
// a status code. The grid size is set through the APB port (rows at 0, columns at 4).
// One word is worked on at a time: the input is not taken again until the result of the
// last word is loaded into the output register. A write word, or a word that is refused,
// goes from decode straight to its result; a start or a step first searches the neighbors.
// Each neighbor search is three row reads of the two bitmaps through their single
// read ports followed by judging the neighbors, and a step that moves searches twice:
// once to move and once to learn whether the new cell ends the trace.
// A finished word waits in the output register while the receiver stalls; the block
// holds its input stall high until that register can take the word.
// Synchronous reset clears both bitmaps at once through per-row valid bits, ends any
// trace and restores 11 rows and 19 columns; no clearing pass is needed.
`default_nettype none

module grid_path_tracer_top
    import gpt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_word           i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_word               o_out_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic [RIU_W-1:0] r_rows_in_use;
    logic [CIU_W-1:0] r_cols_in_use;
    logic             cfg_wr;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    // Registers sit at word addresses; the low address bits are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= RIU_RESET;
            r_cols_in_use <= CIU_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_ROWS) begin
                r_rows_in_use <= pwdata[RIU_W-1:0];
            end else begin
                r_cols_in_use <= pwdata[CIU_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_COLS) ? PDATA_W'(r_cols_in_use)
                                           : PDATA_W'(r_rows_in_use);

    // The controller only sequences; all grid state lives in the datapath.
    gpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    gpt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_cmd         (w_cmd),
        .i_rows_in_use (r_rows_in_use),
        .i_cols_in_use (r_cols_in_use),
        .i_out_stall   (i_out_stall),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .o_out_word    (o_out_word)
    );

`ifndef ASSERT_OFF
    // Once a word is taken, the block is busy until its result is loaded into the output register.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous word still in progress");

    // A result is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output register overwritten before it was taken");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid)
        else $error("loaded result not presented");

    // Map writes and trace starts only happen for cells inside the grid in use.
    a_writes_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.path_wr || w_cmd.start_enter) |-> w_stat.in_range)
        else $error("map changed for a cell outside the grid");
`endif

endmodule

`default_nettype wire

[hw/rtl/gpt_map.sv]
// One bitmap of the grid, stored as rows of MAX_COLS bits with a valid bit per row.
// Depends on gpt_pkg.
`default_nettype none

module gpt_map
    import gpt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_clear,
    input  wire logic                i_wr_en,
    input  wire logic [ROW_W-1:0]    i_wr_row,
    input  wire logic [COL_W-1:0]    i_wr_col,
    input  wire logic                i_wr_bit,
    input  wire logic                i_rd_en,
    input  wire logic [ROW_W-1:0]    i_rd_row,
    output logic [MAX_COLS-1:0]      o_rd_data
);

    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_valid;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_valid;
    logic                keep_row;

    // A row that is not valid reads as zero, so its other bits are zeroed
    // when the first bit of it is written.
    assign keep_row = r_row_valid[i_wr_row] && !i_clear;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                if ((COL_W'(i) == i_wr_col) || !keep_row) begin
                    r_mem[i_wr_row][i] <= (COL_W'(i) == i_wr_col) ? i_wr_bit : 1'b0;
                end
            end
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_row];
            r_rd_valid <= r_row_valid[i_rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else begin
            if (i_clear) begin
                r_row_valid <= '0;
            end
            if (i_wr_en) begin
                r_row_valid[i_wr_row] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

[hw/rtl/gpt_datapath.sv]
// Datapath of the grid path tracer: item and position registers, both bitmaps,
// neighbor evaluation, id arithmetic and the output register. Depends on gpt_pkg, gpt_map.
`default_nettype none

module gpt_datapath
    import gpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_in_word         i_in_word,
    input  wire t_dp_cmd          i_cmd,
    input  wire logic [RIU_W-1:0] i_rows_in_use,
    input  wire logic [CIU_W-1:0] i_cols_in_use,
    input  wire logic             i_out_stall,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output t_out_word             o_out_word
);

    function automatic logic row_ok(input logic [ROW_W:0] r, input logic [RIU_W-1:0] lim);
        return (r < (ROW_W+1)'(lim)) && (r < (ROW_W+1)'(MAX_ROWS));
    endfunction

    function automatic logic col_ok(input logic [COL_W:0] c, input logic [CIU_W-1:0] lim);
        return (c < (COL_W+1)'(lim)) && (c < (COL_W+1)'(MAX_COLS));
    endfunction

    t_in_word            r_in;
    logic [ROW_W-1:0]    r_cur_row;
    logic [COL_W-1:0]    r_cur_col;
    logic                r_active;
    logic                r_dn_ok;
    logic                r_up_ok;
    logic [STAT_W-1:0]   r_res_status;
    logic                r_res_last;
    logic                r_out_valid;
    t_out_word           r_out_word;

    logic [MAX_COLS-1:0] path_q;
    logic [MAX_COLS-1:0] vis_q;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W:0]      row_dn;
    logic [ROW_W:0]      row_up;
    logic [COL_W:0]      col_lf;
    logic [COL_W:0]      col_rt;
    logic [COL_W-1:0]    idx_lf;
    logic [COL_W-1:0]    idx_rt;
    logic                cur_row_ok;
    logic                cur_col_ok;
    logic                dn_ok;
    logic                up_ok;
    logic                lf_ok;
    logic                rt_ok;
    logic [ROW_W-1:0]    next_row;
    logic [COL_W-1:0]    next_col;
    logic [ROW_W-1:0]    vis_wr_row;
    logic [COL_W-1:0]    vis_wr_col;
    logic [ID_W+1:0]     id_full;

    // Neighbor coordinates of the current cell, one bit wider than a coordinate.
    assign row_dn = {1'b0, r_cur_row} + (ROW_W+1)'(1);
    assign row_up = {1'b0, r_cur_row} - (ROW_W+1)'(1);
    assign col_lf = {1'b0, r_cur_col} - (COL_W+1)'(1);
    assign col_rt = {1'b0, r_cur_col} + (COL_W+1)'(1);
    assign idx_lf = col_lf[COL_W-1:0];
    assign idx_rt = col_rt[COL_W-1:0];

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_DN:   rd_row = row_dn[ROW_W-1:0];
            RD_UP:   rd_row = row_up[ROW_W-1:0];
            RD_MID:  rd_row = r_cur_row;
            default: rd_row = r_cur_row;
        endcase
    end

    assign vis_wr_row = i_cmd.start_enter ? r_in.row    : next_row;
    assign vis_wr_col = i_cmd.start_enter ? r_in.column : next_col;

    gpt_map u_path_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (1'b0),
        .i_wr_en   (i_cmd.path_wr),
        .i_wr_row  (r_in.row),
        .i_wr_col  (r_in.column),
        .i_wr_bit  (r_in.cell_on),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (path_q)
    );

    gpt_map u_visited_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (i_cmd.start_enter),
        .i_wr_en   (i_cmd.start_enter | i_cmd.step_enter),
        .i_wr_row  (vis_wr_row),
        .i_wr_col  (vis_wr_col),
        .i_wr_bit  (1'b1),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_row  (rd_row),
        .o_rd_data (vis_q)
    );

    // The middle row is still at the map outputs when the neighbors are judged.
    assign cur_row_ok = row_ok({1'b0, r_cur_row}, i_rows_in_use);
    assign cur_col_ok = col_ok({1'b0, r_cur_col}, i_cols_in_use);
    assign dn_ok = r_dn_ok && row_ok(row_dn, i_rows_in_use) && cur_col_ok;
    assign up_ok = r_up_ok && (r_cur_row != '0) && row_ok(row_up, i_rows_in_use) && cur_col_ok;
    assign lf_ok = (r_cur_col != '0) && cur_row_ok && col_ok(col_lf, i_cols_in_use)
                   && path_q[idx_lf] && !vis_q[idx_lf];
    assign rt_ok = cur_row_ok && col_ok(col_rt, i_cols_in_use)
                   && path_q[idx_rt] && !vis_q[idx_rt];

    always_comb begin
        next_row = r_cur_row;
        next_col = r_cur_col;
        priority if (dn_ok) begin
            next_row = row_dn[ROW_W-1:0];
        end else if (up_ok) begin
            next_row = row_up[ROW_W-1:0];
        end else if (lf_ok) begin
            next_col = idx_lf;
        end else if (rt_ok) begin
            next_col = idx_rt;
        end else begin
            next_row = r_cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end
        if (i_cmd.start_enter) begin
            r_cur_row <= r_in.row;
            r_cur_col <= r_in.column;
        end else if (i_cmd.step_enter) begin
            r_cur_row <= next_row;
            r_cur_col <= next_col;
        end
        if (i_cmd.cap_dn) begin
            r_dn_ok <= path_q[r_cur_col] && !vis_q[r_cur_col];
        end
        if (i_cmd.cap_up) begin
            r_up_ok <= path_q[r_cur_col] && !vis_q[r_cur_col];
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_last   <= i_cmd.res_last;
        end
        if (i_cmd.out_load) begin
            r_out_word.cell_id <= (r_res_status == ST_CELL) ? id_full[ID_W-1:0] : '0;
            r_out_word.last    <= r_res_last;
            r_out_word.status  <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.active_wr) begin
                r_active <= i_cmd.active_val;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign id_full = (ID_W+2)'(r_cur_row) * (ID_W+2)'(i_cols_in_use) + (ID_W+2)'(r_cur_col);

    assign o_stat.action   = r_in.action;
    assign o_stat.in_range = row_ok({1'b0, r_in.row}, i_rows_in_use)
                             && col_ok({1'b0, r_in.column}, i_cols_in_use);
    assign o_stat.active   = r_active;
    assign o_stat.found    = dn_ok || up_ok || lf_ok || rt_ok;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

[hw/rtl/gpt_ctrl.sv]
// Controller of the grid path tracer: sequences decode, neighbor reads, evaluation
// and result hand-off. Depends on gpt_pkg.
`default_nettype none

module gpt_ctrl
    import gpt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_DECODE = 7'b000_0010,
        S_RD_DN  = 7'b000_0100,
        S_RD_UP  = 7'b000_1000,
        S_RD_MID = 7'b001_0000,
        S_EVAL   = 7'b010_0000,
        S_EMIT   = 7'b100_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_after_enter;
    logic   n_after_enter;

    always_comb begin
        o_cmd         = '0;
        o_cmd.rd_sel  = RD_MID;
        n_state       = r_state;
        n_after_enter = r_after_enter;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.res_set    = 1'b1;
                o_cmd.res_status = ST_RANGE;
                n_state          = S_EMIT;
                unique case (i_stat.action)
                    ACT_WRITE: begin
                        if (i_stat.in_range) begin
                            o_cmd.path_wr    = 1'b1;
                            o_cmd.res_status = ST_WRITTEN;
                        end
                    end
                    ACT_START: begin
                        if (i_stat.in_range) begin
                            o_cmd.start_enter = 1'b1;
                            o_cmd.res_set     = 1'b0;
                            n_after_enter     = 1'b1;
                            n_state           = S_RD_DN;
                        end
                    end
                    ACT_STEP: begin
                        if (i_stat.active) begin
                            o_cmd.res_set = 1'b0;
                            n_after_enter = 1'b0;
                            n_state       = S_RD_DN;
                        end else begin
                            o_cmd.res_status = ST_NO_TRACE;
                        end
                    end
                    default: begin
                        o_cmd.res_status = ST_RANGE;
                    end
                endcase
            end
            S_RD_DN: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_DN;
                n_state      = S_RD_UP;
            end
            S_RD_UP: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_UP;
                o_cmd.cap_dn = 1'b1;
                n_state      = S_RD_MID;
            end
            S_RD_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_MID;
                o_cmd.cap_up = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                if (r_after_enter) begin
                    o_cmd.active_wr  = 1'b1;
                    o_cmd.active_val = i_stat.found;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_CELL;
                    o_cmd.res_last   = !i_stat.found;
                    n_state          = S_EMIT;
                end else if (i_stat.found) begin
                    o_cmd.step_enter = 1'b1;
                    n_after_enter    = 1'b1;
                    n_state          = S_RD_DN;
                end else begin
                    o_cmd.active_wr  = 1'b1;
                    o_cmd.active_val = 1'b0;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = ST_NO_TRACE;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_after_enter <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_after_enter <= n_after_enter;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire
